// ===== rtl/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants for the tlb page table translator
// sizes, field widths, sequencer states and transaction payload structs
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGES       = 512;
    localparam int FRAMES      = 256;
    localparam int OFFSET_BITS = 11;
    localparam int STAMP_BITS  = 32;

    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int PAGE_W    = $clog2(PAGES);
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int VADDR_W   = 20;
    localparam int PADDR_W   = 21;
    localparam int BASE_W    = 10;
    localparam int INSTAMP_W = 32;

    localparam logic [BASE_W-1:0] FRAME_BASE_RESET = BASE_W'(455);

    typedef struct packed {
        logic [VADDR_W-1:0]   virtual_addr;
        logic [INSTAMP_W-1:0] stamp;
    } req_t;

    typedef struct packed {
        logic [PADDR_W-1:0] physical_addr;
        logic               tlb_hit;
        logic               page_fault;
        logic               memory_eviction;
        logic [VADDR_W-1:0] evicted_virtual_addr;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_PTRD,
        ST_PTCHK,
        ST_FSCAN,
        ST_FRD,
        ST_FCMP,
        ST_OLDRD,
        ST_OLDWT,
        ST_INVAL,
        ST_COMMIT,
        ST_LRUSCAN,
        ST_FILL,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/tlb_page_table_lru_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_lru_translator: tlb, page table and lru frame translator
// serial tlb search, page table lookup, frame allocation with lru eviction
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  req      in         req_valid/stall  tlbpt_pkg::req_t
//  rsp      out        rsp_valid/stall  tlbpt_pkg::rsp_t
//  cfg      in         cfg_valid/ready  frame_base, 10 bits
// hit: accept, tlb scan one entry a cycle, result
// miss resident: tlb scan, page table read, lru tlb scan, fill
// fault: adds a free frame scan; with every frame used a further lru frame
// search and a pass to drop the old page from the page table and the tlb
// after reset a clearing pass clears the page valid bits
// req is not accepted while a transaction is in flight, a result waits or the clearing pass runs
module tlb_page_table_lru_translator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tlbpt_pkg::req_t    req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tlbpt_pkg::rsp_t    rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [tlbpt_pkg::BASE_W-1:0] cfg_data
);

    localparam int TI = tlbpt_pkg::TLB_IDX_W;
    localparam int PW = tlbpt_pkg::PAGE_W;
    localparam int FW = tlbpt_pkg::FRAME_W;
    localparam int SW = tlbpt_pkg::STAMP_BITS;
    localparam int OB = tlbpt_pkg::OFFSET_BITS;

    tlbpt_pkg::state_t state_reg, state_next;

    logic [tlbpt_pkg::BASE_W-1:0] base_reg;
    logic [PW-1:0] tlb_page_reg [tlbpt_pkg::TLB_ENTRIES];
    logic [FW-1:0] tlb_frame_reg [tlbpt_pkg::TLB_ENTRIES];
    logic [SW-1:0] tlb_use_reg [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] tlb_valid_reg;

    logic [FW-1:0] pt_frame_mem [tlbpt_pkg::PAGES];
    logic          pt_valid_mem [tlbpt_pkg::PAGES];
    logic [PW-1:0] frame_page_mem [tlbpt_pkg::FRAMES];
    logic [SW-1:0] frame_use_mem [tlbpt_pkg::FRAMES];
    logic [tlbpt_pkg::FRAMES-1:0] frame_used_reg;

    logic          clr_busy_reg;
    logic [PW:0]   clr_cnt_reg;

    logic [OB-1:0] off_reg;
    logic [PW-1:0] page_reg;
    logic [SW-1:0] stamp_reg;
    logic [TI:0]   ti_reg;
    logic [FW:0]   fi_reg;
    logic [FW-1:0] frame_reg;
    logic [PW-1:0] old_reg;
    logic [SW-1:0] best_reg;
    logic [TI-1:0] slot_reg;
    logic          found_reg;
    logic          fault_reg, evict_reg;
    logic [FW-1:0] pt_frame_q;
    logic          pt_valid_q;
    logic [SW-1:0] fuse_q;
    logic [PW-1:0] fpage_q;
    tlbpt_pkg::rsp_t rsp_reg;

    logic [TI-1:0] ti;
    logic [FW-1:0] fi;
    logic [tlbpt_pkg::BASE_W:0] pfn;

    assign ti = ti_reg[TI-1:0];
    assign fi = fi_reg[FW-1:0];
    assign pfn = {1'b0, base_reg} + (tlbpt_pkg::BASE_W+1)'(frame_reg);

    assign req_stall = (state_reg != tlbpt_pkg::ST_IDLE) || clr_busy_reg;
    assign cfg_ready = 1'b1;
    assign rsp_valid = (state_reg == tlbpt_pkg::ST_OUT);
    assign rsp = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlbpt_pkg::ST_IDLE:
                if (req_valid && !req_stall) state_next = tlbpt_pkg::ST_TSCAN;
            tlbpt_pkg::ST_TSCAN:
                if (tlb_valid_reg[ti] && tlb_page_reg[ti] == page_reg)
                    state_next = tlbpt_pkg::ST_OUT;
                else if (ti_reg == (TI+1)'(tlbpt_pkg::TLB_ENTRIES - 1))
                    state_next = tlbpt_pkg::ST_PTRD;
            tlbpt_pkg::ST_PTRD:    state_next = tlbpt_pkg::ST_PTCHK;
            tlbpt_pkg::ST_PTCHK:
                state_next = pt_valid_q ? tlbpt_pkg::ST_COMMIT : tlbpt_pkg::ST_FSCAN;
            tlbpt_pkg::ST_FSCAN:
                if (!frame_used_reg[fi]) state_next = tlbpt_pkg::ST_COMMIT;
                else if (fi_reg == (FW+1)'(tlbpt_pkg::FRAMES - 1))
                    state_next = tlbpt_pkg::ST_FRD;
            tlbpt_pkg::ST_FRD:     state_next = tlbpt_pkg::ST_FCMP;
            tlbpt_pkg::ST_FCMP:
                state_next = (fi_reg == (FW+1)'(tlbpt_pkg::FRAMES - 1))
                    ? tlbpt_pkg::ST_OLDRD : tlbpt_pkg::ST_FRD;
            tlbpt_pkg::ST_OLDRD:   state_next = tlbpt_pkg::ST_OLDWT;
            tlbpt_pkg::ST_OLDWT:   state_next = tlbpt_pkg::ST_INVAL;
            tlbpt_pkg::ST_INVAL:
                if (ti_reg == (TI+1)'(tlbpt_pkg::TLB_ENTRIES - 1))
                    state_next = tlbpt_pkg::ST_COMMIT;
            tlbpt_pkg::ST_COMMIT:  state_next = tlbpt_pkg::ST_LRUSCAN;
            tlbpt_pkg::ST_LRUSCAN:
                if (ti_reg == (TI+1)'(tlbpt_pkg::TLB_ENTRIES - 1))
                    state_next = tlbpt_pkg::ST_FILL;
            tlbpt_pkg::ST_FILL:    state_next = tlbpt_pkg::ST_OUT;
            tlbpt_pkg::ST_OUT:
                if (!rsp_stall) state_next = tlbpt_pkg::ST_IDLE;
            default:               state_next = tlbpt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlbpt_pkg::ST_IDLE;
            base_reg       <= tlbpt_pkg::FRAME_BASE_RESET;
            tlb_valid_reg  <= '0;
            frame_used_reg <= '0;
            clr_busy_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) base_reg <= cfg_data;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (PW+1)'(tlbpt_pkg::PAGES - 1)) clr_busy_reg <= 1'b0;
            end
            case (state_reg)
                tlbpt_pkg::ST_INVAL:
                    if (tlb_valid_reg[ti] && tlb_page_reg[ti] == old_reg)
                        tlb_valid_reg[ti] <= 1'b0;
                tlbpt_pkg::ST_COMMIT:
                    if (fault_reg) frame_used_reg[frame_reg] <= 1'b1;
                tlbpt_pkg::ST_FILL:
                    tlb_valid_reg[slot_reg] <= 1'b1;
                default: ;
            endcase
        end
    end

    // page table and frame stores
    always_ff @(posedge clk)
    begin
        pt_frame_q <= pt_frame_mem[page_reg];
        pt_valid_q <= pt_valid_mem[page_reg];
        fuse_q     <= frame_use_mem[fi];
        fpage_q    <= frame_page_mem[frame_reg];
        if (clr_busy_reg)
            pt_valid_mem[clr_cnt_reg[PW-1:0]] <= 1'b0;
        else if (state_reg == tlbpt_pkg::ST_OLDWT)
            pt_valid_mem[fpage_q] <= 1'b0;
        else if (state_reg == tlbpt_pkg::ST_COMMIT && fault_reg)
        begin
            pt_valid_mem[page_reg] <= 1'b1;
            pt_frame_mem[page_reg] <= frame_reg;
        end
        if (state_reg == tlbpt_pkg::ST_COMMIT)
        begin
            frame_use_mem[frame_reg] <= stamp_reg;
            if (fault_reg) frame_page_mem[frame_reg] <= page_reg;
        end
        else if (state_reg == tlbpt_pkg::ST_TSCAN && state_next == tlbpt_pkg::ST_OUT)
            frame_use_mem[tlb_frame_reg[ti]] <= stamp_reg;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            tlbpt_pkg::ST_IDLE:
            begin
                off_reg   <= req.virtual_addr[OB-1:0];
                page_reg  <= req.virtual_addr[OB +: PW];
                stamp_reg <= req.stamp[SW-1:0];
                ti_reg    <= '0;
                fi_reg    <= '0;
                fault_reg <= 1'b0;
                evict_reg <= 1'b0;
                old_reg   <= '0;
            end
            tlbpt_pkg::ST_TSCAN:
            begin
                ti_reg <= ti_reg + 1'b1;
                if (tlb_valid_reg[ti] && tlb_page_reg[ti] == page_reg)
                begin
                    tlb_use_reg[ti]  <= stamp_reg;
                    frame_reg        <= tlb_frame_reg[ti];
                    rsp_reg.physical_addr <= tlbpt_pkg::PADDR_W'(
                        {({1'b0, base_reg} + (tlbpt_pkg::BASE_W+1)'(tlb_frame_reg[ti])),
                         off_reg});
                    rsp_reg.tlb_hit <= 1'b1;
                    rsp_reg.page_fault <= 1'b0;
                    rsp_reg.memory_eviction <= 1'b0;
                    rsp_reg.evicted_virtual_addr <= '0;
                end
            end
            tlbpt_pkg::ST_PTCHK:
            begin
                frame_reg <= pt_frame_q;
                fault_reg <= !pt_valid_q;
            end
            tlbpt_pkg::ST_FSCAN:
            begin
                if (!frame_used_reg[fi])
                    frame_reg <= fi;
                else if (fi_reg == (FW+1)'(tlbpt_pkg::FRAMES - 1))
                    fi_reg <= '0;
                else
                    fi_reg <= fi_reg + 1'b1;
            end
            tlbpt_pkg::ST_FCMP:
            begin
                fi_reg <= fi_reg + 1'b1;
                if (fi_reg == '0 || fuse_q < best_reg)
                begin
                    best_reg  <= fuse_q;
                    frame_reg <= fi;
                end
            end
            tlbpt_pkg::ST_OLDWT:
            begin
                old_reg   <= fpage_q;
                evict_reg <= 1'b1;
                ti_reg    <= '0;
            end
            tlbpt_pkg::ST_INVAL:
                ti_reg <= ti_reg + 1'b1;
            tlbpt_pkg::ST_COMMIT:
            begin
                ti_reg    <= '0;
                found_reg <= 1'b0;
                rsp_reg.physical_addr <= tlbpt_pkg::PADDR_W'({pfn, off_reg});
                rsp_reg.tlb_hit <= 1'b0;
                rsp_reg.page_fault <= fault_reg;
                rsp_reg.memory_eviction <= evict_reg;
                rsp_reg.evicted_virtual_addr <= evict_reg
                    ? tlbpt_pkg::VADDR_W'({old_reg, off_reg}) : '0;
            end
            tlbpt_pkg::ST_LRUSCAN:
            begin
                ti_reg <= ti_reg + 1'b1;
                if (!found_reg)
                begin
                    if (!tlb_valid_reg[ti])
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= ti;
                    end
                    else if (ti_reg == '0 || tlb_use_reg[ti] < best_reg)
                    begin
                        best_reg <= tlb_use_reg[ti];
                        slot_reg <= ti;
                    end
                end
            end
            tlbpt_pkg::ST_FILL:
            begin
                tlb_page_reg[slot_reg]  <= page_reg;
                tlb_frame_reg[slot_reg] <= frame_reg;
                tlb_use_reg[slot_reg]   <= stamp_reg;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_req_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tlbpt_pkg::ST_IDLE) |-> req_stall)
        else $error("request accepted while busy");
    a_evict_implies_fault: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.memory_eviction |-> rsp.page_fault && !rsp.tlb_hit)
        else $error("eviction without page fault");
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.tlb_hit |-> !rsp.page_fault)
        else $error("hit with page fault");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");
`endif

endmodule

// ===== tb/tlb_translator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_translator_checker: translation predictor and response scoreboard
// watches the request, response and frame base channels, keeps its own tlb,
// page table and frame lru state, and compares every response field by field
// ----------------------------------------------------------------------------
module tlb_translator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  tlbpt_pkg::req_t               req,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  tlbpt_pkg::rsp_t               rsp,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tlbpt_pkg::BASE_W-1:0]  cfg_data,
    output int                            mismatches,
    output int                            pending
);

    logic [tlbpt_pkg::BASE_W-1:0]     base_q;
    logic [tlbpt_pkg::PAGE_W-1:0]     t_page [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0]    t_frame [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::STAMP_BITS-1:0] t_use [tlbpt_pkg::TLB_ENTRIES];
    logic                             t_valid [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0]    p_frame [tlbpt_pkg::PAGES];
    logic                             p_valid [tlbpt_pkg::PAGES];
    logic [tlbpt_pkg::PAGE_W-1:0]     f_page [tlbpt_pkg::FRAMES];
    logic [tlbpt_pkg::STAMP_BITS-1:0] f_use [tlbpt_pkg::FRAMES];
    logic                             f_used [tlbpt_pkg::FRAMES];
    tlbpt_pkg::rsp_t                  expected_rsp [$];

    function automatic logic [tlbpt_pkg::PADDR_W-1:0] phys_of(
        logic [tlbpt_pkg::FRAME_W-1:0] fr, logic [tlbpt_pkg::OFFSET_BITS-1:0] off);
        logic [tlbpt_pkg::BASE_W:0] pfn;
        pfn = {1'b0, base_q} + (tlbpt_pkg::BASE_W+1)'(fr);
        return tlbpt_pkg::PADDR_W'({pfn, off});
    endfunction

    function automatic tlbpt_pkg::rsp_t translate(tlbpt_pkg::req_t r);
        tlbpt_pkg::rsp_t                  o;
        logic [tlbpt_pkg::OFFSET_BITS-1:0] off;
        logic [tlbpt_pkg::PAGE_W-1:0]     pg;
        logic [tlbpt_pkg::PAGE_W-1:0]     old;
        logic [tlbpt_pkg::FRAME_W-1:0]    fr;
        logic [tlbpt_pkg::STAMP_BITS-1:0] best;
        int                               slot;
        int                               f;
        off = r.virtual_addr[tlbpt_pkg::OFFSET_BITS-1:0];
        pg = r.virtual_addr[tlbpt_pkg::OFFSET_BITS +: tlbpt_pkg::PAGE_W];
        o = '0;
        fr = '0;
        for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
        begin
            if (t_valid[i] && t_page[i] == pg)
            begin
                fr = t_frame[i];
                o.tlb_hit = 1'b1;
                t_use[i] = r.stamp;
                f_use[fr] = r.stamp;
                break;
            end
        end
        if (!o.tlb_hit)
        begin
            if (p_valid[pg])
            begin
                fr = p_frame[pg];
                f_use[fr] = r.stamp;
            end
            else
            begin
                o.page_fault = 1'b1;
                f = -1;
                for (int i = 0; i < tlbpt_pkg::FRAMES; i++)
                begin
                    if (!f_used[i])
                    begin
                        f = i;
                        break;
                    end
                end
                if (f < 0)
                begin
                    f = 0;
                    best = f_use[0];
                    for (int i = 1; i < tlbpt_pkg::FRAMES; i++)
                    begin
                        if (f_use[i] < best)
                        begin
                            best = f_use[i];
                            f = i;
                        end
                    end
                    old = f_page[f];
                    o.memory_eviction = 1'b1;
                    o.evicted_virtual_addr = tlbpt_pkg::VADDR_W'({old, off});
                    p_valid[old] = 1'b0;
                    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
                        if (t_valid[i] && t_page[i] == old)
                            t_valid[i] = 1'b0;
                end
                fr = tlbpt_pkg::FRAME_W'(f);
                f_page[fr] = pg;
                f_use[fr] = r.stamp;
                f_used[fr] = 1'b1;
                p_frame[pg] = fr;
                p_valid[pg] = 1'b1;
            end
            slot = -1;
            for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
            begin
                if (!t_valid[i])
                begin
                    slot = i;
                    break;
                end
            end
            if (slot < 0)
            begin
                slot = 0;
                best = t_use[0];
                for (int i = 1; i < tlbpt_pkg::TLB_ENTRIES; i++)
                begin
                    if (t_use[i] < best)
                    begin
                        best = t_use[i];
                        slot = i;
                    end
                end
            end
            t_page[slot] = pg;
            t_frame[slot] = fr;
            t_use[slot] = r.stamp;
            t_valid[slot] = 1'b1;
        end
        o.physical_addr = phys_of(fr, off);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_q <= tlbpt_pkg::FRAME_BASE_RESET;
            mismatches <= 0;
            pending <= 0;
            for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
            begin
                t_page[i] = '0;
                t_frame[i] = '0;
                t_use[i] = '0;
                t_valid[i] = 1'b0;
            end
            for (int i = 0; i < tlbpt_pkg::PAGES; i++)
            begin
                p_valid[i] = 1'b0;
                p_frame[i] = '0;
            end
            for (int i = 0; i < tlbpt_pkg::FRAMES; i++)
            begin
                f_used[i] = 1'b0;
                f_page[i] = '0;
                f_use[i] = '0;
            end
            expected_rsp.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                base_q <= cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected response %h", rsp);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    tlbpt_pkg::rsp_t e;
                    e = expected_rsp.pop_front();
                    if (e.physical_addr !== rsp.physical_addr
                        || e.tlb_hit !== rsp.tlb_hit
                        || e.page_fault !== rsp.page_fault
                        || e.memory_eviction !== rsp.memory_eviction
                        || e.evicted_virtual_addr !== rsp.evicted_virtual_addr)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected pa %h hit %b pf %b ev %b eva %h,",
                                     e.physical_addr, e.tlb_hit, e.page_fault,
                                     e.memory_eviction, e.evicted_virtual_addr,
                                     " actual pa %h hit %b pf %b ev %b eva %h",
                                     rsp.physical_addr, rsp.tlb_hit, rsp.page_fault,
                                     rsp.memory_eviction, rsp.evicted_virtual_addr);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsp.push_back(translate(req));
            pending <= expected_rsp.size();
        end
    end

endmodule

// ===== tb/tlb_page_table_lru_translator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_lru_translator_tb: stimulus and verdict for the translator
// directed and random translation requests over several frame base settings,
// with bursty requests, random response stalls and a checker alongside
// ----------------------------------------------------------------------------
module tlb_page_table_lru_translator_tb;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    tlbpt_pkg::req_t              req = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    tlbpt_pkg::rsp_t              rsp;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [tlbpt_pkg::BASE_W-1:0] cfg_data = '0;
    int                           mismatches;
    int                           pending;
    int                           stall_mode = 0;
    logic [31:0]                  stamp_ctr = 32'd1000;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tlb_page_table_lru_translator u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    tlb_translator_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    // receiver stall pattern, mode changes every phase
    always @(posedge clk)
    begin
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic send_req(logic [tlbpt_pkg::VADDR_W-1:0] va, logic [31:0] st);
        @(posedge clk);
        req_valid <= 1'b1;
        req.virtual_addr <= va;
        req.stamp <= st;
        do @(posedge clk); while (req_stall);
        req_valid <= 1'b0;
    endtask

    task automatic gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_base(logic [tlbpt_pkg::BASE_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic next_stamp(output logic [31:0] st);
        stamp_ctr = stamp_ctr + $urandom_range(1, 5);
        st = stamp_ctr;
    endtask

    task automatic random_phase(int count, int page_span);
        logic [31:0]                   st;
        logic [tlbpt_pkg::VADDR_W-1:0] va;
        int                            burst;
        int                            done_cnt;
        done_cnt = 0;
        while (done_cnt < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                va = tlbpt_pkg::VADDR_W'($urandom);
                if ($urandom_range(0, 4) != 0)
                    va[19:11] = tlbpt_pkg::PAGE_W'($urandom_range(0, page_span - 1));
                if ($urandom_range(0, 7) == 0)
                    st = $urandom;
                else
                    next_stamp(st);
                send_req(va, st);
                done_cnt++;
            end
            gap();
        end
    endtask

    initial
    begin
        logic [31:0] st;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes, hits, resident tlb misses, stamp ties and extremes
        send_req(20'h00000, 32'd0);
        send_req(20'h007FF, 32'd0);
        send_req(20'hFFFFF, 32'hFFFFFFFF);
        send_req(20'hFF800, 32'd5);
        send_req(20'h00800, 32'd5);
        send_req(20'h00801, 32'd5);
        for (int i = 0; i < 18; i++)
            send_req(tlbpt_pkg::VADDR_W'((i + 3) << 11) | tlbpt_pkg::VADDR_W'(i * 97),
                     32'd7);
        send_req(20'h00000, 32'd9);
        drain();
        write_base(10'd0);
        send_req(20'h00ABC, 32'd10);
        drain();
        write_base(10'h3FF);
        send_req(20'hFFFFF, 32'hFFFFFFFE);
        drain();
        // fill memory beyond 256 frames to force evictions
        stall_mode = 1;
        write_base(10'd768);
        for (int i = 0; i < 300; i++)
        begin
            next_stamp(st);
            send_req(tlbpt_pkg::VADDR_W'(((i * 7) % tlbpt_pkg::PAGES) << 11)
                     | tlbpt_pkg::VADDR_W'($urandom_range(0, 2047)), st);
        end
        drain();
        stall_mode = 2;
        write_base(10'd207);
        random_phase(100, 24);
        drain();
        stall_mode = 3;
        write_base(10'd455);
        random_phase(60, 512);
        drain();
        stall_mode = 0;
        write_base(tlbpt_pkg::FRAME_BASE_RESET);
        random_phase(60, 300);
        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
